FILE: sv/bonded_device_table_fifo_evict_top_defines.svh
// ----------------------------------------------------------------------------
// Bonded device table assertion macros
// Shared assertion forms for the port checker of the bonded device table.
// ----------------------------------------------------------------------------
`ifndef BONDED_DEVICE_TABLE_FIFO_EVICT_TOP_DEFINES_SVH
`define BONDED_DEVICE_TABLE_FIFO_EVICT_TOP_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define BDT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another in the next cycle.
`define BDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bdt_pkg.sv
// ----------------------------------------------------------------------------
// Bonded device table package
// Sizes, codes and control structs shared by the table modules.
// ----------------------------------------------------------------------------
package bdt_pkg;

  // Table geometry.
  localparam int DEPTH       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int NUM_W       = (CNT_W > 4) ? CNT_W : 4;

  // Field widths.
  localparam int ACT_W   = 2;
  localparam int ADDR_W  = 48;
  localparam int PROTO_W = 4;
  localparam int LIM_W   = 4;
  localparam int OUTC_W  = 3;
  localparam int ECNT_W  = 4;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_SAVE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Outcome codes.
  localparam logic [OUTC_W-1:0] OUTC_UPDATED = 3'd0;
  localparam logic [OUTC_W-1:0] OUTC_ADDED   = 3'd1;
  localparam logic [OUTC_W-1:0] OUTC_EVICTED = 3'd2;
  localparam logic [OUTC_W-1:0] OUTC_CLEARED = 3'd3;
  localparam logic [OUTC_W-1:0] OUTC_READ    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              idx_clr;
    logic              idx_inc;
    logic              do_update;
    logic              do_append;
    logic              do_evict;
    logic              do_clear;
    logic              out_load;
    logic              out_entry;
    logic [OUTC_W-1:0] outcome;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             match;
    logic             scan_end;
    logic             full;
    logic             read_empty;
    logic             read_last;
    logic             out_free;
  } dp_status_t;

endpackage

FILE: sv/bdt_in_if.sv
// ----------------------------------------------------------------------------
// Bonded device table input channel
// Valid/ready channel carrying one action word.
// ----------------------------------------------------------------------------
interface bdt_in_if;
  logic                          valid;
  logic                          ready;
  logic [bdt_pkg::ACT_W-1:0]     action;
  logic [bdt_pkg::ADDR_W-1:0]    device_address;
  logic [bdt_pkg::PROTO_W-1:0]   protocol_code;
  logic [bdt_pkg::LIM_W-1:0]     read_limit;

  modport source (output valid, action, device_address, protocol_code, read_limit,
                  input ready);
  modport sink (input valid, action, device_address, protocol_code, read_limit,
                output ready);
endinterface

FILE: sv/bdt_out_if.sv
// ----------------------------------------------------------------------------
// Bonded device table result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface bdt_out_if;
  logic                          valid;
  logic                          ready;
  logic [bdt_pkg::OUTC_W-1:0]    outcome;
  logic                          entry_valid;
  logic [bdt_pkg::ADDR_W-1:0]    entry_address;
  logic [bdt_pkg::PROTO_W-1:0]   entry_protocol;
  logic [bdt_pkg::ECNT_W-1:0]    entry_count;
  logic                          last;

  modport source (output valid, outcome, entry_valid, entry_address, entry_protocol,
                  entry_count, last, input ready);
  modport sink (input valid, outcome, entry_valid, entry_address, entry_protocol,
                entry_count, last, output ready);
endinterface

FILE: sv/bdt_ctrl.sv
// ----------------------------------------------------------------------------
// Bonded device table controller
// Sequences the address scan, table updates and result emission.
// ----------------------------------------------------------------------------
module bdt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bdt_pkg::dp_status_t    status,
  output bdt_pkg::ctrl_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_RESULT = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [bdt_pkg::OUTC_W-1:0]   outcome_r, outcome_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    outcome_nxt   = outcome_r;
    cmd           = '0;
    cmd.outcome   = outcome_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.action)
          bdt_pkg::ACT_SAVE: begin
            state_nxt = S_SCAN;
          end
          bdt_pkg::ACT_READ: begin
            outcome_nxt = bdt_pkg::OUTC_READ;
            state_nxt   = status.read_empty ? S_RESULT : S_EMIT;
          end
          bdt_pkg::ACT_CLEAR: begin
            cmd.do_clear = 1'b1;
            outcome_nxt  = bdt_pkg::OUTC_CLEARED;
            state_nxt    = S_RESULT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // The scan ends at the fill count; entries past it are never compared.
        if (status.scan_end) begin
          if (status.full) begin
            cmd.do_evict = 1'b1;
            outcome_nxt  = bdt_pkg::OUTC_EVICTED;
          end else begin
            cmd.do_append = 1'b1;
            outcome_nxt   = bdt_pkg::OUTC_ADDED;
          end
          state_nxt = S_RESULT;
        end else if (status.match) begin
          cmd.do_update = 1'b1;
          outcome_nxt   = bdt_pkg::OUTC_UPDATED;
          state_nxt     = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_entry = 1'b1;
          cmd.idx_inc   = 1'b1;
          if (status.read_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      outcome_r <= bdt_pkg::OUTC_UPDATED;
    end else begin
      state_r   <= state_nxt;
      outcome_r <= outcome_nxt;
    end
  end

endmodule

FILE: sv/bdt_dpath.sv
// ----------------------------------------------------------------------------
// Bonded device table datapath
// Holds the ordered table, fill count, scan index and output register.
// ----------------------------------------------------------------------------
module bdt_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bdt_pkg::ctrl_cmd_t              cmd,
  output bdt_pkg::dp_status_t             status,
  input  logic [bdt_pkg::ACT_W-1:0]       in_action,
  input  logic [bdt_pkg::ADDR_W-1:0]      in_address,
  input  logic [bdt_pkg::PROTO_W-1:0]     in_protocol,
  input  logic [bdt_pkg::LIM_W-1:0]       in_limit,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [bdt_pkg::OUTC_W-1:0]      out_outcome,
  output logic                            out_entry_valid,
  output logic [bdt_pkg::ADDR_W-1:0]      out_entry_address,
  output logic [bdt_pkg::PROTO_W-1:0]     out_entry_protocol,
  output logic [bdt_pkg::ECNT_W-1:0]      out_entry_count,
  output logic                            out_last
);

  // Table storage, oldest entry at position zero.
  logic [bdt_pkg::ADDR_W-1:0]   addr_tbl_r  [bdt_pkg::DEPTH];
  logic [bdt_pkg::PROTO_W-1:0]  proto_tbl_r [bdt_pkg::DEPTH];

  // Captured input word.
  logic [bdt_pkg::ACT_W-1:0]    action_r;
  logic [bdt_pkg::ADDR_W-1:0]   addr_r;
  logic [bdt_pkg::PROTO_W-1:0]  proto_r;
  logic [bdt_pkg::LIM_W-1:0]    limit_r;

  logic [bdt_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [bdt_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic [bdt_pkg::IDX_W-1:0]    idx_sel;
  logic [bdt_pkg::IDX_W-1:0]    cnt_sel;
  logic [bdt_pkg::NUM_W-1:0]    cnt_ext, lim_ext, run_len;
  logic [bdt_pkg::NUM_W-1:0]    idx_next_ext;
  logic                         read_last;

  assign idx_sel = idx_r[bdt_pkg::IDX_W-1:0];
  assign cnt_sel = count_r[bdt_pkg::IDX_W-1:0];

  // Run length of a read: the smallest of count, limit and the result cap.
  assign cnt_ext = bdt_pkg::NUM_W'(count_r);
  assign lim_ext = bdt_pkg::NUM_W'(limit_r);
  always_comb begin
    run_len = (cnt_ext < lim_ext) ? cnt_ext : lim_ext;
    if (run_len > bdt_pkg::NUM_W'(bdt_pkg::MAX_RESULTS)) begin
      run_len = bdt_pkg::NUM_W'(bdt_pkg::MAX_RESULTS);
    end
  end
  assign idx_next_ext = bdt_pkg::NUM_W'(idx_r) + bdt_pkg::NUM_W'(1);
  assign read_last    = (idx_next_ext == run_len);

  // Status toward the controller.
  always_comb begin
    status.action     = action_r;
    status.match      = (addr_tbl_r[idx_sel] == addr_r);
    status.scan_end   = (idx_r == count_r);
    status.full       = (count_r == bdt_pkg::CNT_W'(bdt_pkg::DEPTH));
    status.read_empty = (run_len == '0);
    status.read_last  = read_last;
    status.out_free   = !out_valid_r || out_ready;
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      addr_r   <= in_address;
      proto_r  <= in_protocol;
      limit_r  <= in_limit;
    end
  end

  // Table writes: shift on eviction, append at the fill count, or update in place.
  always_ff @(posedge clk) begin
    if (cmd.do_evict) begin
      for (int i = 0; i < bdt_pkg::DEPTH - 1; i++) begin
        addr_tbl_r[i]  <= addr_tbl_r[i+1];
        proto_tbl_r[i] <= proto_tbl_r[i+1];
      end
      addr_tbl_r[bdt_pkg::DEPTH-1]  <= addr_r;
      proto_tbl_r[bdt_pkg::DEPTH-1] <= proto_r;
    end else if (cmd.do_append) begin
      addr_tbl_r[cnt_sel]  <= addr_r;
      proto_tbl_r[cnt_sel] <= proto_r;
    end else if (cmd.do_update) begin
      proto_tbl_r[idx_sel] <= proto_r;
    end
  end

  // Fill count, scan index and output valid.
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_clear) begin
      count_nxt = '0;
    end else if (cmd.do_append) begin
      count_nxt = count_r + bdt_pkg::CNT_W'(1);
    end

    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + bdt_pkg::CNT_W'(1);
    end

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry_count <= bdt_pkg::ECNT_W'(count_r);
      if (cmd.out_entry) begin
        out_outcome        <= bdt_pkg::OUTC_READ;
        out_entry_valid    <= 1'b1;
        out_entry_address  <= addr_tbl_r[idx_sel];
        out_entry_protocol <= proto_tbl_r[idx_sel];
        out_last           <= read_last;
      end else begin
        out_outcome        <= cmd.outcome;
        out_entry_valid    <= 1'b0;
        out_entry_address  <= '0;
        out_entry_protocol <= '0;
        out_last           <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/bonded_device_table_fifo_evict_top.sv
// ----------------------------------------------------------------------------
// Bonded device table with oldest-first replacement
// Ordered table of device addresses and protocol codes; save, read, clear.
// ----------------------------------------------------------------------------
// A save scans the table one entry per cycle from position zero to the fill
// count, then loads its result once the output register is free.
// A clear or an empty read loads its result once the output register is free;
// a read run loads one entry per cycle while the output register is free.
// A new word is accepted in the cycle after the last result is registered.
// Reset is synchronous: the fill count is cleared, emptying the table, and the output valid is cleared.
module bonded_device_table_fifo_evict_top (
  input  logic       clk,
  input  logic       rst_n,
  bdt_in_if.sink     in_ch,
  bdt_out_if.source  out_ch
);

  bdt_pkg::ctrl_cmd_t   cmd;
  bdt_pkg::dp_status_t  status;

  // Sequencer.
  bdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Table and output register.
  bdt_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_action          (in_ch.action),
    .in_address         (in_ch.device_address),
    .in_protocol        (in_ch.protocol_code),
    .in_limit           (in_ch.read_limit),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_outcome        (out_ch.outcome),
    .out_entry_valid    (out_ch.entry_valid),
    .out_entry_address  (out_ch.entry_address),
    .out_entry_protocol (out_ch.entry_protocol),
    .out_entry_count    (out_ch.entry_count),
    .out_last           (out_ch.last)
  );

endmodule

FILE: sv/bdt_checker.sv
// ----------------------------------------------------------------------------
// Bonded device table port checker
// Watches the top-level channels and flags illegal result sequences.
// ----------------------------------------------------------------------------
`include "bonded_device_table_fifo_evict_top_defines.svh"

module bdt_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [bdt_pkg::OUTC_W-1:0]    out_outcome,
  input  logic                          out_entry_valid,
  input  logic                          out_last
);

  // A stalled result word stays offered.
  `BDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  // The block works on one word at a time, so it is busy right after an accept.
  `BDT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted on consecutive cycles")

  // Only read results carry a table entry.
  `BDT_ASSERT_SAME(a_entry_is_read, clk, rst_n, out_valid && out_entry_valid, out_outcome == bdt_pkg::OUTC_READ, "entry shown on a non-read result")

  // Save and clear produce a single word, which is always marked last.
  `BDT_ASSERT_SAME(a_single_last, clk, rst_n, out_valid && (out_outcome != bdt_pkg::OUTC_READ), out_last, "non-read result not marked last")

endmodule

bind bonded_device_table_fifo_evict_top bdt_checker u_bdt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_outcome     (out_ch.outcome),
  .out_entry_valid (out_ch.entry_valid),
  .out_last        (out_ch.last)
);
